// ===== hw/rtl/iirdf1_pkg.sv =====
// ----------------------------------------------------------------------------
// iirdf1_pkg
// Shared types and constants of the direct form I IIR filter.
// ----------------------------------------------------------------------------
package iirdf1_pkg;

	localparam int DEFAULT_MAX_TAPS       = 16;
	localparam int DEFAULT_COEF_FRAC_BITS = 24;

	localparam int SAMPLE_W  = 16;
	localparam int COEF_W    = 32;
	localparam int COUNT_W   = 5;
	localparam int ACTION_W  = 2;
	localparam int COEF_IDX_W = 4;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 32;

	localparam logic [ACTION_W-1:0] ACT_FILTER   = ACTION_W'(0);
	localparam logic [ACTION_W-1:0] ACT_WRITE_FB = ACTION_W'(1);
	localparam logic [ACTION_W-1:0] ACT_WRITE_FF = ACTION_W'(2);

	localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_COUNT    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FEEDFORWARD_COUNT = CFG_IDX_W'(1);

	typedef struct packed {
		logic [ACTION_W-1:0]        action;
		logic signed [SAMPLE_W-1:0] sample_in;
		logic                       block_start;
		logic [COEF_IDX_W-1:0]      coef_index;
		logic signed [COEF_W-1:0]   coef_value;
	} item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_out;
		logic                       saturated;
	} result_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  reg_index;
		logic [CFG_DATA_W-1:0] write_data;
	} cfg_t;

	typedef struct packed {
		logic clear;
		logic valid;
		logic negate;
	} mac_ctl_t;

endpackage

// ===== hw/rtl/iirdf1_stream_if.sv =====
// ----------------------------------------------------------------------------
// iirdf1_stream_if
// Valid/ready channel that moves one word of type payload_t per handshake.
// ----------------------------------------------------------------------------
interface iirdf1_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/iirdf1_mac.sv =====
// ----------------------------------------------------------------------------
// iirdf1_mac
// Multiply-accumulate datapath with half-up rounding and 16-bit saturation.
// ----------------------------------------------------------------------------
module iirdf1_mac #(
	parameter int MAX_TAPS       = iirdf1_pkg::DEFAULT_MAX_TAPS,
	parameter int COEF_FRAC_BITS = iirdf1_pkg::DEFAULT_COEF_FRAC_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  iirdf1_pkg::mac_ctl_t                  ctl,
	input  logic signed [iirdf1_pkg::COEF_W-1:0]   coef_s1,
	input  logic signed [iirdf1_pkg::SAMPLE_W-1:0] hist_s1,
	output logic                                  busy,
	output iirdf1_pkg::result_t                   res
);
	localparam int COEF_W   = iirdf1_pkg::COEF_W;
	localparam int SAMPLE_W = iirdf1_pkg::SAMPLE_W;
	localparam int PROD_W   = COEF_W + SAMPLE_W;
	localparam int ACC_W    = PROD_W + $clog2(2 * MAX_TAPS) + 1;

	localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(1) << (COEF_FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] POS_LIM = (ACC_W'(1) << (SAMPLE_W - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] NEG_LIM = -(ACC_W'(1) << (SAMPLE_W - 1));

	logic signed [PROD_W-1:0] coef_ext;
	logic signed [PROD_W-1:0] hist_ext;
	logic signed [PROD_W-1:0] product_s2;
	logic                     valid_s2;
	logic                     negate_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  prod_acc;
	logic signed [ACC_W-1:0]  rnd_sum;
	logic signed [ACC_W-1:0]  rnd_shift;

	assign coef_ext = PROD_W'(coef_s1);
	assign hist_ext = PROD_W'(hist_s1);
	assign prod_acc = ACC_W'(product_s2);
	assign busy     = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		product_s2 <= PROD_W'(coef_ext * hist_ext);
		negate_s2  <= ctl.negate;
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= negate_s2 ? acc_q - prod_acc : acc_q + prod_acc;
		end
	end

	assign rnd_sum   = acc_q + HALF;
	assign rnd_shift = rnd_sum >>> COEF_FRAC_BITS;

	always_comb begin
		priority if (rnd_shift > POS_LIM) begin
			res.sample_out = POS_LIM[SAMPLE_W-1:0];
			res.saturated  = 1'b1;
		end else if (rnd_shift < NEG_LIM) begin
			res.sample_out = NEG_LIM[SAMPLE_W-1:0];
			res.saturated  = 1'b1;
		end else begin
			res.sample_out = rnd_shift[SAMPLE_W-1:0];
			res.saturated  = 1'b0;
		end
	end

endmodule

// ===== hw/rtl/iir_filter_direct_form_one.sv =====
// ----------------------------------------------------------------------------
// iir_filter_direct_form_one
// Direct form I IIR filter on 16-bit samples with Q8.24 coefficients.
// ----------------------------------------------------------------------------
//  channel    | dir | word     | content
//  item_ch    | in  | item_t   | action, sample_in, block_start, coef_index, coef_value
//  result_ch  | out | result_t | sample_out, saturated
//  cfg_ch     | in  | cfg_t    | reg_index, write_data (low 5 bits used)
//
// A coefficient write leaves the filter idle. A filter word steps through its used
// feedforward taps, then its used feedback taps, and then drains the multiplier;
// one shared multiplier reads one coefficient and one history sample per cycle.
// Reset gives the pass-through filter; no clearing pass is needed.
// The next word is taken while a result waits; a finished word stalls only
// when the output register is still full.
// ----------------------------------------------------------------------------
module iir_filter_direct_form_one #(
	parameter int MAX_TAPS       = iirdf1_pkg::DEFAULT_MAX_TAPS,
	parameter int COEF_FRAC_BITS = iirdf1_pkg::DEFAULT_COEF_FRAC_BITS
) (
	input  logic            clk,
	input  logic            arst_n,
	iirdf1_stream_if.sink   item_ch,
	iirdf1_stream_if.source result_ch,
	iirdf1_stream_if.sink   cfg_ch
);
	localparam int COEF_W   = iirdf1_pkg::COEF_W;
	localparam int SAMPLE_W = iirdf1_pkg::SAMPLE_W;
	localparam int COUNT_W  = iirdf1_pkg::COUNT_W;
	localparam int IDX_W    = $clog2(MAX_TAPS);
	localparam int CNT_W    = $clog2(MAX_TAPS + 1);

	localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC_BITS;

	localparam logic SEL_FF = 1'b0;
	localparam logic SEL_FB = 1'b1;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	iirdf1_pkg::item_t    item;
	iirdf1_pkg::cfg_t     cfg;
	iirdf1_pkg::result_t  mac_res;
	iirdf1_pkg::result_t  result_q;
	iirdf1_pkg::mac_ctl_t mac_ctl;

	logic [1:0]         state_q;
	logic [COUNT_W-1:0] fb_count_q;
	logic [COUNT_W-1:0] ff_count_q;
	logic [IDX_W-1:0]   ptr_q;
	logic [CNT_W-1:0]   seen_q;
	logic [CNT_W-1:0]   nff_q;
	logic [CNT_W-1:0]   nfb_q;
	logic               phase_q;
	logic [CNT_W-1:0]   tap_q;
	logic               out_valid_q;

	logic signed [COEF_W-1:0]   coef_mem [2][MAX_TAPS];
	logic signed [SAMPLE_W-1:0] hist_mem [2][MAX_TAPS];
	logic [1:0][MAX_TAPS-1:0]   coef_valid_q;

	logic signed [COEF_W-1:0]   coef_rd_s1;
	logic signed [SAMPLE_W-1:0] hist_rd_s1;
	logic                       rd_valid_s1;
	logic                       negate_s1;
	logic                       coef_ok_s1;
	logic                       coef_one_s1;
	logic signed [COEF_W-1:0]   coef_s1;
	logic                       mac_busy;

	logic               item_acc;
	logic               cfg_acc;
	logic               filter_go;
	logic               coef_we;
	logic               coef_wsel;
	logic [IDX_W-1:0]   coef_waddr;
	logic               issue;
	logic               finish;
	logic               out_free;
	logic               hist_we;
	logic               hist_wsel;
	logic [IDX_W-1:0]   hist_waddr;
	logic signed [SAMPLE_W-1:0] hist_wdata;
	logic [IDX_W-1:0]   p_eff;
	logic [CNT_W-1:0]   seen_eff;
	logic [CNT_W-1:0]   na;
	logic [CNT_W-1:0]   nb;
	logic [CNT_W-1:0]   nff_d;
	logic [CNT_W-1:0]   nfb_d;
	logic [CNT_W:0]     p_ext;
	logic [CNT_W:0]     t_ext;
	logic [CNT_W:0]     ring;
	logic [IDX_W-1:0]   rd_caddr;
	logic [IDX_W-1:0]   rd_haddr;

	assign item = item_ch.payload;
	assign cfg  = cfg_ch.payload;

	assign item_ch.ready    = (state_q == ST_IDLE);
	assign cfg_ch.ready     = 1'b1;
	assign result_ch.valid  = out_valid_q;
	assign result_ch.payload = result_q;

	assign item_acc = item_ch.valid && item_ch.ready;
	assign cfg_acc  = cfg_ch.valid && cfg_ch.ready;
	assign out_free = !out_valid_q || result_ch.ready;

	// Tap counts of this word: a tap is used only once its history exists.
	always_comb begin
		p_eff    = item.block_start ? '0 : ptr_q;
		seen_eff = item.block_start ? '0 : seen_q;
		na = (32'(fb_count_q) > MAX_TAPS) ? CNT_W'(MAX_TAPS) : CNT_W'(fb_count_q);
		nb = (32'(ff_count_q) > MAX_TAPS) ? CNT_W'(MAX_TAPS) : CNT_W'(ff_count_q);
		nff_d = (nb > seen_eff) ? seen_eff + CNT_W'(1) : nb;
		if (na == '0) begin
			nfb_d = '0;
		end else begin
			nfb_d = ((na - CNT_W'(1)) > seen_eff) ? seen_eff : na - CNT_W'(1);
		end
	end

	always_comb begin
		p_ext    = (CNT_W + 1)'(ptr_q);
		t_ext    = (CNT_W + 1)'(tap_q);
		ring     = (p_ext >= t_ext) ? p_ext - t_ext
		                            : p_ext + (CNT_W + 1)'(MAX_TAPS) - t_ext;
		rd_haddr = IDX_W'(ring);
		rd_caddr = IDX_W'(tap_q);
	end

	always_comb begin
		filter_go  = 1'b0;
		coef_we    = 1'b0;
		coef_wsel  = (item.action == iirdf1_pkg::ACT_WRITE_FB) ? SEL_FB : SEL_FF;
		coef_waddr = IDX_W'(item.coef_index);
		issue      = 1'b0;
		finish     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_acc) begin
					unique case (item.action)
						iirdf1_pkg::ACT_FILTER: begin
							filter_go = 1'b1;
						end
						iirdf1_pkg::ACT_WRITE_FB, iirdf1_pkg::ACT_WRITE_FF: begin
							coef_we = (32'(item.coef_index) < MAX_TAPS);
						end
						default: begin
						end
					endcase
				end
			end
			ST_RUN: begin
				issue = (phase_q == SEL_FF) ? (tap_q < nff_q) : (tap_q <= nfb_q);
			end
			ST_DRAIN: begin
			end
			ST_DONE: begin
				finish = out_free;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		hist_we    = filter_go || finish;
		hist_wsel  = finish ? SEL_FB : SEL_FF;
		hist_waddr = finish ? ptr_q : p_eff;
		hist_wdata = finish ? mac_res.sample_out : item.sample_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fb_count_q   <= COUNT_W'(0);
			ff_count_q   <= COUNT_W'(1);
			ptr_q        <= '0;
			seen_q       <= '0;
			nff_q        <= '0;
			nfb_q        <= '0;
			phase_q      <= SEL_FF;
			tap_q        <= '0;
			out_valid_q  <= 1'b0;
			coef_valid_q <= '0;
			rd_valid_s1  <= 1'b0;
		end else begin
			rd_valid_s1 <= issue;
			if (cfg_acc) begin
				if (cfg.reg_index == iirdf1_pkg::REG_FEEDBACK_COUNT) begin
					fb_count_q <= cfg.write_data[COUNT_W-1:0];
				end else if (cfg.reg_index == iirdf1_pkg::REG_FEEDFORWARD_COUNT) begin
					ff_count_q <= cfg.write_data[COUNT_W-1:0];
				end
			end
			if (coef_we) begin
				coef_valid_q[coef_wsel][coef_waddr] <= 1'b1;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (filter_go) begin
						state_q <= ST_RUN;
						ptr_q   <= p_eff;
						seen_q  <= seen_eff;
						nff_q   <= nff_d;
						nfb_q   <= nfb_d;
						phase_q <= SEL_FF;
						tap_q   <= '0;
					end
				end
				ST_RUN: begin
					if (issue) begin
						tap_q <= tap_q + CNT_W'(1);
					end else if (phase_q == SEL_FF) begin
						phase_q <= SEL_FB;
						tap_q   <= CNT_W'(1);
					end else begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!rd_valid_s1 && !mac_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (finish) begin
						state_q <= ST_IDLE;
						ptr_q   <= (32'(ptr_q) == MAX_TAPS - 1) ? '0 : ptr_q + IDX_W'(1);
						if (32'(seen_q) < MAX_TAPS) begin
							seen_q <= seen_q + CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_mem[coef_wsel][coef_waddr] <= item.coef_value;
		end
		if (issue) begin
			coef_rd_s1 <= coef_mem[phase_q][rd_caddr];
		end
	end

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[hist_wsel][hist_waddr] <= hist_wdata;
		end
		if (issue) begin
			hist_rd_s1 <= hist_mem[phase_q][rd_haddr];
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			negate_s1   <= (phase_q == SEL_FB);
			coef_ok_s1  <= coef_valid_q[phase_q][rd_caddr];
			coef_one_s1 <= (phase_q == SEL_FF) && (tap_q == '0);
		end
		if (finish) begin
			result_q <= mac_res;
		end
	end

	// A coefficient never written reads as its reset value.
	assign coef_s1 = coef_ok_s1 ? coef_rd_s1 : (coef_one_s1 ? COEF_ONE : '0);

	assign mac_ctl.clear  = filter_go;
	assign mac_ctl.valid  = rd_valid_s1;
	assign mac_ctl.negate = negate_s1;

	iirdf1_mac #(
		.MAX_TAPS       (MAX_TAPS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mac_ctl),
		.coef_s1 (coef_s1),
		.hist_s1 (hist_rd_s1),
		.busy    (mac_busy),
		.res     (mac_res)
	);

	a_done_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> out_valid_q)
		else $error("finished word did not reach the output register");

	a_ptr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(ptr_q) < MAX_TAPS) && (32'(seen_q) <= MAX_TAPS))
		else $error("history pointer or sample count out of range");

	a_read_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> (state_q == ST_RUN || state_q == ST_DRAIN))
		else $error("history read outside of a filter word");

	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_valid_s1 || mac_busy) |-> (state_q != ST_IDLE))
		else $error("new word taken while the accumulator is still busy");

endmodule

// ===== tb/iir_filter_direct_form_one_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_filter_direct_form_one_tb
// Self-checking bench for the direct form I IIR filter. A scoreboard keeps its
// own copy of coefficients, histories and tap counts, predicts every filtered
// word from the accepted input words, and compares it with the result channel.
// Directed words cover pass-through, rounding and saturation; random buffers
// with coefficient writes then run under several tap-count settings and
// changing handshake pressure on both sides.
// ----------------------------------------------------------------------------
module iir_filter_direct_form_one_tb;
	import iirdf1_pkg::*;

	localparam int TAPS = DEFAULT_MAX_TAPS;
	localparam int FRAC = DEFAULT_COEF_FRAC_BITS;
	localparam logic [ACTION_W-1:0] ACT_UNUSED = ACTION_W'(3);
	localparam int DRAIN_CYCLES = 64;
	localparam int QUIET_LIMIT = 3000;
	localparam int STALL_CYCLES = 400;
	localparam int PHASES = 8;
	localparam int WORDS_PER_PHASE = 85;

	class iir_scoreboard;
		logic [COUNT_W-1:0] fb_count;
		logic [COUNT_W-1:0] ff_count;
		logic signed [COEF_W-1:0] fb_coef[TAPS];
		logic signed [COEF_W-1:0] ff_coef[TAPS];
		logic signed [SAMPLE_W-1:0] x_hist[TAPS];
		logic signed [SAMPLE_W-1:0] y_hist[TAPS];
		int unsigned ptr;
		int unsigned since_start;
		result_t expected_q[$];
		int unsigned mismatches;

		function new();
			fb_count = '0;
			ff_count = COUNT_W'(1);
			foreach (fb_coef[i]) begin
				fb_coef[i] = '0;
				ff_coef[i] = '0;
			end
			ff_coef[0] = COEF_W'(1) << FRAC;
			clear_histories();
			mismatches = 0;
		endfunction

		function void clear_histories();
			foreach (x_hist[i]) begin
				x_hist[i] = '0;
				y_hist[i] = '0;
			end
			ptr = 0;
			since_start = 0;
		endfunction

		function int unsigned clamp(logic [COUNT_W-1:0] c);
			return (c > TAPS) ? TAPS : int'(c);
		endfunction

		function void note_config(cfg_t w);
			if (w.reg_index == REG_FEEDBACK_COUNT)
				fb_count = w.write_data[COUNT_W-1:0];
			else if (w.reg_index == REG_FEEDFORWARD_COUNT)
				ff_count = w.write_data[COUNT_W-1:0];
		endfunction

		function void note_item(item_t it);
			longint acc;
			longint r;
			int unsigned na;
			int unsigned nb;
			int unsigned p;
			bit sat;
			result_t e;
			if (it.action == ACT_WRITE_FB) begin
				if (it.coef_index < TAPS)
					fb_coef[it.coef_index] = it.coef_value;
				return;
			end
			if (it.action == ACT_WRITE_FF) begin
				if (it.coef_index < TAPS)
					ff_coef[it.coef_index] = it.coef_value;
				return;
			end
			if (it.action != ACT_FILTER)
				return;
			if (it.block_start)
				clear_histories();
			p = ptr;
			x_hist[p] = it.sample_in;
			na = clamp(fb_count);
			nb = clamp(ff_count);
			acc = 0;
			for (int unsigned j = 0; j < nb; j++)
				if (j <= since_start)
					acc += longint'(ff_coef[j]) * longint'(x_hist[(p + TAPS - j) % TAPS]);
			for (int unsigned j = 1; j < na; j++)
				if (j <= since_start)
					acc -= longint'(fb_coef[j]) * longint'(y_hist[(p + TAPS - j) % TAPS]);
			acc += longint'(1) << (FRAC - 1);
			r = acc >>> FRAC;
			sat = 1'b0;
			if (r > 32767) begin
				r = 32767;
				sat = 1'b1;
			end
			if (r < -32768) begin
				r = -32768;
				sat = 1'b1;
			end
			y_hist[p] = r[SAMPLE_W-1:0];
			ptr = (p + 1) % TAPS;
			if (since_start < TAPS)
				since_start++;
			e.sample_out = r[SAMPLE_W-1:0];
			e.saturated = sat;
			expected_q.push_back(e);
		endfunction

		function void check_result(result_t r);
			result_t e;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, actual sample_out %0d saturated %0b",
					$time, r.sample_out, r.saturated);
				mismatches++;
				return;
			end
			e = expected_q.pop_front();
			if (r.sample_out !== e.sample_out) begin
				$display("%0t: sample_out mismatch, expected %0d, actual %0d",
					$time, e.sample_out, r.sample_out);
				mismatches++;
			end
			if (r.saturated !== e.saturated) begin
				$display("%0t: saturated mismatch, expected %0b, actual %0b",
					$time, e.saturated, r.saturated);
				mismatches++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;
	int unsigned hold_left;
	int unsigned quiet_cycles;
	iir_scoreboard sb = new();

	iirdf1_stream_if #(.payload_t(item_t))   item_ch();
	iirdf1_stream_if #(.payload_t(result_t)) result_ch();
	iirdf1_stream_if #(.payload_t(cfg_t))    cfg_ch();

	iir_filter_direct_form_one dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_ch   (item_ch),
		.result_ch (result_ch),
		.cfg_ch    (cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		hold_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				result_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready)
				sb.check_result(result_ch.payload);
			if (item_ch.valid && item_ch.ready)
				sb.note_item(item_ch.payload);
			if (cfg_ch.valid && cfg_ch.ready)
				sb.note_config(cfg_ch.payload);
			if ((result_ch.valid && result_ch.ready) || (item_ch.valid && item_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Valid stays high after a handshake; the next call either idles or offers a new word.
	task automatic send_item(item_t it);
		while ($urandom_range(99) < tx_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.payload <= it;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.payload <= '{reg_index: idx, write_data: data};
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_counts(logic [COUNT_W-1:0] a, logic [COUNT_W-1:0] b);
		logic [CFG_DATA_W-1:0] data;
		wait_idle();
		data = CFG_DATA_W'($urandom);
		data[COUNT_W-1:0] = a;
		write_reg(REG_FEEDBACK_COUNT, data);
		data = CFG_DATA_W'($urandom);
		data[COUNT_W-1:0] = b;
		write_reg(REG_FEEDFORWARD_COUNT, data);
		write_reg(CFG_IDX_W'($urandom_range(2, (1 << CFG_IDX_W) - 1)), CFG_DATA_W'($urandom));
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic item_t mk(logic [ACTION_W-1:0] act, int smp, bit bs, int idx, int val);
		item_t it;
		it.action = act;
		it.sample_in = SAMPLE_W'(smp);
		it.block_start = bs;
		it.coef_index = COEF_IDX_W'(idx);
		it.coef_value = COEF_W'(val);
		return it;
	endfunction

	function automatic item_t random_item();
		item_t it;
		it.action = ACTION_W'($urandom);
		it.sample_in = SAMPLE_W'($urandom);
		it.block_start = 1'(($urandom));
		it.coef_index = COEF_IDX_W'($urandom);
		it.coef_value = COEF_W'($urandom);
		return it;
	endfunction

	function automatic logic [SAMPLE_W-1:0] random_sample();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 50)
			return SAMPLE_W'($urandom);
		if (pick < 80)
			return SAMPLE_W'($urandom_range(512) - 256);
		case ($urandom_range(4))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0001;
			3: return 16'hFFFF;
			default: return 16'h0000;
		endcase
	endfunction

	function automatic logic [COEF_W-1:0] random_coef();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 45)
			return COEF_W'($urandom_range(1 << (FRAC - 1)) - (1 << (FRAC - 2)));
		if (pick < 80)
			return COEF_W'($urandom_range(1 << (FRAC + 1)) - (1 << FRAC));
		return COEF_W'($urandom);
	endfunction

	task automatic run_directed();
		item_t seq[$];
		seq.push_back(mk(ACT_FILTER, 32767, 1, 0, 0));
		seq.push_back(mk(ACT_FILTER, -32768, 0, 0, 0));
		seq.push_back(mk(ACT_FILTER, 1, 0, 0, 0));
		seq.push_back(mk(ACT_FILTER, -1, 0, 0, 0));
		seq.push_back(mk(ACT_FILTER, 0, 0, 0, 0));
		seq.push_back(mk(ACT_WRITE_FB, 0, 1, 0, 32'h7FFF_FFFF));
		seq.push_back(mk(ACT_UNUSED, -1, 1, 15, -1));
		seq.push_back(mk(ACT_FILTER, 100, 0, 0, 0));
		seq.push_back(mk(ACT_WRITE_FF, 0, 0, 0, 32'h7FFF_FFFF));
		seq.push_back(mk(ACT_FILTER, 32767, 0, 0, 0));
		seq.push_back(mk(ACT_FILTER, -32768, 0, 0, 0));
		seq.push_back(mk(ACT_WRITE_FF, 0, 0, 0, 32'h8000_0000));
		seq.push_back(mk(ACT_FILTER, -32768, 1, 0, 0));
		seq.push_back(mk(ACT_FILTER, 32767, 0, 0, 0));
		seq.push_back(mk(ACT_WRITE_FF, 0, 0, 0, 1 << (FRAC - 1)));
		seq.push_back(mk(ACT_FILTER, 1, 0, 0, 0));
		seq.push_back(mk(ACT_FILTER, -1, 0, 0, 0));
		seq.push_back(mk(ACT_FILTER, 3, 0, 0, 0));
		seq.push_back(mk(ACT_FILTER, -3, 0, 0, 0));
		seq.push_back(mk(ACT_WRITE_FF, 0, 0, 15, -1));
		seq.push_back(mk(ACT_WRITE_FB, 0, 0, 15, 1 << FRAC));
		seq.push_back(mk(ACT_WRITE_FF, 0, 0, 0, 1 << FRAC));
		seq.push_back(mk(ACT_FILTER, 7, 0, 0, 0));
		foreach (seq[i])
			send_item(seq[i]);
	endtask

	task automatic send_buffer(inout int unsigned sent);
		item_t it;
		int unsigned n_writes;
		int unsigned len;
		n_writes = $urandom_range(1) ? $urandom_range(1, 4) : 0;
		for (int unsigned k = 0; k < n_writes; k++) begin
			it = random_item();
			it.action = $urandom_range(1) ? ACT_WRITE_FB : ACT_WRITE_FF;
			it.coef_value = random_coef();
			send_item(it);
			sent++;
		end
		len = ($urandom_range(99) < 70) ? $urandom_range(1, 20) : $urandom_range(17, 40);
		for (int unsigned k = 0; k < len; k++) begin
			it = random_item();
			if ($urandom_range(99) < 4) begin
				it.action = ACT_UNUSED;
				send_item(it);
			end else begin
				it.action = ACT_FILTER;
				it.block_start = (k == 0) || ($urandom_range(99) < 3);
				it.sample_in = random_sample();
				send_item(it);
				sent++;
			end
		end
	endtask

	initial begin
		logic [COUNT_W-1:0] fb_set[PHASES];
		logic [COUNT_W-1:0] ff_set[PHASES];
		int unsigned sent;
		fb_set = '{5'd2, 5'd16, 5'd31, 5'd0, 5'd1, 5'd16, 5'd0, 5'd0};
		ff_set = '{5'd3, 5'd16, 5'd31, 5'd0, 5'd16, 5'd1, 5'd0, 5'd0};
		arst_n = 1'b0;
		quiet_cycles = 0;
		tx_idle_pct = 33;
		rx_idle_pct = 72;
		item_ch.valid <= 1'b0;
		item_ch.payload <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.payload <= '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		run_directed();
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph < 3) begin
				tx_idle_pct = 33;
				rx_idle_pct = 72;
			end else if (ph < 6) begin
				tx_idle_pct = 72;
				rx_idle_pct = 33;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			if (ph >= 6)
				set_counts(COUNT_W'($urandom_range(31)), COUNT_W'($urandom_range(31)));
			else
				set_counts(fb_set[ph], ff_set[ph]);
			// Hold the result side off so that the filter backs up into its input.
			if (ph == 0)
				hold_left = STALL_CYCLES;
			sent = 0;
			while (sent < WORDS_PER_PHASE)
				send_buffer(sent);
		end
		item_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/iirdf1_pkg.sv
hw/rtl/iirdf1_stream_if.sv
hw/rtl/iirdf1_mac.sv
hw/rtl/iir_filter_direct_form_one.sv
tb/iir_filter_direct_form_one_tb.sv
